[rtl/bldc_pkg.sv]
// ============================================================================
// bldc_pkg
// Types, constants and helper functions for the six-step commutator.
// ============================================================================
package bldc_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int CMP_W       = 16;
    localparam int PERIOD_W    = (COUNT_WIDTH < CMP_W) ? COUNT_WIDTH : CMP_W;
    localparam int ANGLE_W     = 16;
    localparam int DUTY_W      = 16;
    localparam int LEVEL_W     = 17;
    localparam int DEG_W       = 9;

    localparam int PERIOD_RESET = 1000;

    // level is Q1.16, one is 65536
    localparam int LEVEL_ONE  = 65536;
    localparam int LEVEL_HALF = 32768;
    // clamp thresholds 0.05 and 0.95 of full scale
    localparam int LEVEL_LOW  = (LEVEL_ONE + 19) / 20;
    localparam int LEVEL_HIGH = (19 * LEVEL_ONE) / 20;

    // modulo 360 by reciprocal multiply
    localparam int FULL_TURN   = 360;
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP       = (1 << RECIP_SHIFT) / FULL_TURN + 1;
    localparam int RECIP_W     = 16;
    localparam int QUOT_W      = 7;

    localparam int PHASE_V_OFFSET = 120;
    localparam int PHASE_W_OFFSET = 240;

    localparam int SECTOR_A_START  = 60;
    localparam int SECTOR_FLOAT_B  = 180;
    localparam int SECTOR_B_START  = 240;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic CFG_IDX_PERIOD = 1'b0;

    typedef enum logic [1:0] {
        CMD_DRIVE = 2'd0,
        CMD_LOCK  = 2'd1,
        CMD_FREE  = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        SEC_FLOAT,
        SEC_HIGH,
        SEC_LOW
    } t_sector;

    typedef enum logic [1:0] {
        CLAMP_ZERO,
        CLAMP_FULL,
        CLAMP_SCALE
    } t_clamp;

    typedef struct packed {
        logic                 en;
        t_clamp               clamp;
        logic [LEVEL_W-1:0]   level;
    } t_phase_mid;

    function automatic t_sector sector_of(input logic [DEG_W-1:0] deg);
        t_sector s;
        if (deg < DEG_W'(SECTOR_A_START)) begin
            s = SEC_FLOAT;
        end else if (deg < DEG_W'(SECTOR_FLOAT_B)) begin
            s = SEC_HIGH;
        end else if (deg < DEG_W'(SECTOR_B_START)) begin
            s = SEC_FLOAT;
        end else begin
            s = SEC_LOW;
        end
        return s;
    endfunction

    function automatic logic [DEG_W-1:0] add_offset(input logic [DEG_W-1:0] deg,
                                                    input logic [DEG_W-1:0] ofs);
        logic [DEG_W:0] sum;
        sum = {1'b0, deg} + {1'b0, ofs};
        if (sum >= (DEG_W+1)'(FULL_TURN)) begin
            sum = sum - (DEG_W+1)'(FULL_TURN);
        end
        return sum[DEG_W-1:0];
    endfunction

    function automatic t_phase_mid phase_mid(input t_sector sec,
                                             input logic signed [DUTY_W-1:0] duty);
        t_phase_mid m;
        logic signed [LEVEL_W:0] lvl;
        lvl = '0;
        m.en    = 1'b0;
        m.clamp = CLAMP_ZERO;
        m.level = '0;
        if (sec != SEC_FLOAT) begin
            if (sec == SEC_HIGH) begin
                lvl = (LEVEL_W+1)'(LEVEL_HALF) + (LEVEL_W+1)'(duty);
            end else begin
                lvl = (LEVEL_W+1)'(LEVEL_HALF) - (LEVEL_W+1)'(duty);
            end
            m.en    = 1'b1;
            m.level = lvl[LEVEL_W-1:0];
            if (m.level < LEVEL_W'(LEVEL_LOW)) begin
                m.clamp = CLAMP_ZERO;
            end else if (m.level > LEVEL_W'(LEVEL_HIGH)) begin
                m.clamp = CLAMP_FULL;
            end else begin
                m.clamp = CLAMP_SCALE;
            end
        end
        return m;
    endfunction

endpackage

[rtl/bldc_six_step_commutator.sv]
// ============================================================================
// bldc_six_step_commutator
// Six-step commutation: angle and signed duty to three-phase gate enables
// and PWM compare counts.
// ============================================================================
// Takes one request per clock while the output is not stalled: the request
// lands in an input register, the angle is reduced modulo 360 with a
// reciprocal multiply and the phase levels are formed into a middle register,
// and the levels are scaled by the PWM period with one multiplier per phase
// into the result register. A drive request with a negative angle, or an
// unused command code, is consumed and gives no result. The PWM period is
// written over the APB port at offset 0 and should only change while idle.
module bldc_six_step_commutator
    import bldc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [31:0]            s_axis_tdata,  // angle, duty_level
    input  logic [1:0]             s_axis_tuser,  // cmd

    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // enable_u, enable_v, enable_w, compare_u, compare_v, compare_w, zero pad
    output logic [55:0]            m_axis_tdata,

    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [CFG_ADDR_W-1:0]  paddr,
    input  logic [CFG_DATA_W-1:0]  pwdata,
    output logic [CFG_DATA_W-1:0]  prdata,
    output logic                   pready
);

    logic [PERIOD_W-1:0] r_period;

    logic                       r_a_valid;
    logic [1:0]                 r_a_cmd;
    logic [ANGLE_W-1:0]         r_a_angle;
    logic signed [DUTY_W-1:0]   r_a_duty;

    logic          r_b_valid;
    t_phase_mid    r_b_ph [3];
    t_phase_mid    n_b_ph [3];

    logic              r_o_valid;
    logic [2:0]        r_o_en;
    logic [CMP_W-1:0]  r_o_cmp [3];
    logic [CMP_W-1:0]  n_o_cmp [3];

    logic ready_o, ready_b, ready_a;
    logic s_accept, keep;

    logic [ANGLE_W-2+RECIP_W:0]  prod_q;
    logic [QUOT_W-1:0]           quot;
    logic [ANGLE_W-1:0]          rem_full;
    logic [DEG_W-1:0]            deg_u, deg_v, deg_w;

    logic [LEVEL_W+PERIOD_W-1:0] prod_s [3];

    // configuration
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_W'(PERIOD_RESET);
        end else if (psel && penable && pwrite && paddr[2] == CFG_IDX_PERIOD) begin
            r_period <= pwdata[PERIOD_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == CFG_IDX_PERIOD) begin
            prdata = CFG_DATA_W'(r_period);
        end
    end

    // flow control
    assign ready_o       = !r_o_valid || m_axis_tready;
    assign ready_b       = !r_b_valid || ready_o;
    assign ready_a       = !r_a_valid || ready_b;
    assign s_axis_tready = ready_a;
    assign s_accept      = s_axis_tvalid && ready_a;

    always_comb begin
        unique case (s_axis_tuser)
            CMD_DRIVE: keep = !s_axis_tdata[ANGLE_W-1];
            CMD_LOCK:  keep = 1'b1;
            CMD_FREE:  keep = 1'b1;
            default:   keep = 1'b0;
        endcase
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (ready_a) begin
            r_a_valid <= s_accept && keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_a) begin
            r_a_cmd   <= s_axis_tuser;
            r_a_angle <= s_axis_tdata[ANGLE_W-1:0];
            r_a_duty  <= s_axis_tdata[ANGLE_W +: DUTY_W];
        end
    end

    // angle modulo 360 and phase levels
    always_comb begin
        prod_q   = r_a_angle[ANGLE_W-2:0] * RECIP_W'(RECIP);
        quot     = prod_q[RECIP_SHIFT +: QUOT_W];
        rem_full = {1'b0, r_a_angle[ANGLE_W-2:0]} - ANGLE_W'(quot * ANGLE_W'(FULL_TURN));
        if (rem_full >= ANGLE_W'(FULL_TURN)) begin
            rem_full = rem_full - ANGLE_W'(FULL_TURN);
        end
        deg_u = rem_full[DEG_W-1:0];
        deg_v = add_offset(deg_u, DEG_W'(PHASE_V_OFFSET));
        deg_w = add_offset(deg_u, DEG_W'(PHASE_W_OFFSET));

        n_b_ph[0] = phase_mid(sector_of(deg_u), r_a_duty);
        n_b_ph[1] = phase_mid(sector_of(deg_v), r_a_duty);
        n_b_ph[2] = phase_mid(sector_of(deg_w), r_a_duty);

        if (r_a_cmd != CMD_DRIVE) begin
            for (int i = 0; i < 3; i++) begin
                n_b_ph[i].en    = (r_a_cmd == CMD_LOCK);
                n_b_ph[i].clamp = CLAMP_ZERO;
                n_b_ph[i].level = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (ready_b) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_b) begin
            r_b_ph <= n_b_ph;
        end
    end

    // period scaling
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            prod_s[i] = r_b_ph[i].level * r_period;
            unique case (r_b_ph[i].clamp)
                CLAMP_ZERO:  n_o_cmp[i] = '0;
                CLAMP_FULL:  n_o_cmp[i] = CMP_W'(r_period);
                CLAMP_SCALE: n_o_cmp[i] = CMP_W'(prod_s[i][LEVEL_W-1 +: PERIOD_W]);
                default:     n_o_cmp[i] = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (ready_o) begin
            r_o_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_o) begin
            r_o_en  <= {r_b_ph[2].en, r_b_ph[1].en, r_b_ph[0].en};
            r_o_cmp <= n_o_cmp;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {5'b0, r_o_cmp[2], r_o_cmp[1], r_o_cmp[0], r_o_en};

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the six-step commutator against its own predictor of gate enables and
// PWM compare counts. Directed requests cover sector edges, duty extremes, the
// clamp thresholds, lock, free, unused and negative-angle requests. Random
// requests then run over several PWM periods, including zero and full scale,
// with random stalls on both stream sides, except during the full-scale run.
// ----------------------------------------------------------------------------
module testbench;
    import bldc_pkg::*;

    localparam logic [1:0]            CMD_UNUSED    = 2'd3;
    localparam logic [CFG_ADDR_W-1:0] ADDR_PERIOD   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] ADDR_UNMAPPED = 3'd4;
    localparam int                    IDLE_LIMIT    = 2000;
    localparam int                    PHASE_ITEMS   = 200;
    localparam int                    SETTLE_CYCLES = 8;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [15:0] angle;
        logic signed [15:0] duty;
    } t_req;

    typedef struct packed {
        logic        en_u;
        logic        en_v;
        logic        en_w;
        logic [15:0] cmp_u;
        logic [15:0] cmp_v;
        logic [15:0] cmp_w;
    } t_gate;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [31:0]           s_axis_tdata = '0;   // angle, duty_level
    logic [1:0]            s_axis_tuser = '0;   // cmd
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // enable_u, enable_v, enable_w, compare_u, compare_v, compare_w, zero pad
    logic [55:0]           m_axis_tdata;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    t_req        pending_requests[$];
    t_gate       expected_gates[$];
    logic [15:0] pwm_period_model = 16'(PERIOD_RESET);
    bit          req_fire = 1'b0;
    bit          no_stall = 1'b0;
    int          fail_count = 0;
    int          idle_cycles = 0;
    int          n_requests = 0;
    int          n_drive = 0;
    int          n_lock = 0;
    int          n_free = 0;
    int          n_dropped = 0;
    int          n_results = 0;
    int          n_periods = 1;

    bldc_six_step_commutator DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #6 i_clk = ~i_clk;

    // enable and compare of one phase, packed as {en, compare}
    function automatic logic [16:0] phase_gate(input int unsigned deg, input int duty,
                                               input logic [15:0] period);
        int unsigned s;
        longint      lvl;
        logic [15:0] c;
        s = deg % FULL_TURN;
        if (s < SECTOR_A_START || (s >= SECTOR_FLOAT_B && s < SECTOR_B_START)) begin
            return 17'd0;
        end
        lvl = (s < SECTOR_FLOAT_B) ? longint'(LEVEL_HALF + duty)
                                   : longint'(LEVEL_HALF - duty);
        if (lvl * 20 < LEVEL_ONE) begin
            c = 16'd0;
        end else if (lvl * 20 > longint'(19) * LEVEL_ONE) begin
            c = period;
        end else begin
            c = 16'((lvl * longint'(period)) >> 16);
        end
        return {1'b1, c};
    endfunction

    function automatic bit predict_gates(input t_req r, input logic [15:0] period,
                                         output t_gate g);
        int          a;
        logic [16:0] pu;
        logic [16:0] pv;
        logic [16:0] pw;
        g = '0;
        a = int'(r.angle);
        case (r.cmd)
            CMD_LOCK: begin
                g.en_u = 1'b1;
                g.en_v = 1'b1;
                g.en_w = 1'b1;
                return 1'b1;
            end
            CMD_FREE: begin
                return 1'b1;
            end
            CMD_DRIVE: begin
                if (a < 0) begin
                    return 1'b0;
                end
                pu = phase_gate(a, int'(r.duty), period);
                pv = phase_gate(a + PHASE_V_OFFSET, int'(r.duty), period);
                pw = phase_gate(a + PHASE_W_OFFSET, int'(r.duty), period);
                {g.en_u, g.cmp_u} = pu;
                {g.en_v, g.cmp_v} = pv;
                {g.en_w, g.cmp_w} = pw;
                return 1'b1;
            end
            default: begin
                return 1'b0;
            end
        endcase
    endfunction

    // request driver
    always @(negedge i_clk) begin : drive_requests
        t_req r;
        if (i_rst_n && (!s_axis_tvalid || req_fire)) begin
            if (pending_requests.size() > 0 && (no_stall || $urandom_range(99) >= 10)) begin
                r = pending_requests.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {r.duty, r.angle};
                s_axis_tuser  <= r.cmd;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
        m_axis_tready <= no_stall || ($urandom_range(99) >= 10);
    end

    // accepted requests, result checks, watchdog
    always @(posedge i_clk) begin : watch_streams
        t_req  r;
        t_gate g;
        t_gate got;
        bit    has;
        req_fire <= s_axis_tvalid && s_axis_tready;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                r.cmd   = s_axis_tuser;
                r.angle = s_axis_tdata[15:0];
                r.duty  = s_axis_tdata[31:16];
                has = predict_gates(r, pwm_period_model, g);
                if (has) begin
                    expected_gates.push_back(g);
                end
                n_requests++;
                case (r.cmd)
                    CMD_LOCK:  n_lock++;
                    CMD_FREE:  n_free++;
                    CMD_DRIVE: n_drive++;
                    default:   ;
                endcase
                if (!has) begin
                    n_dropped++;
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.en_u  = m_axis_tdata[0];
                got.en_v  = m_axis_tdata[1];
                got.en_w  = m_axis_tdata[2];
                got.cmp_u = m_axis_tdata[18:3];
                got.cmp_v = m_axis_tdata[34:19];
                got.cmp_w = m_axis_tdata[50:35];
                n_results++;
                if (expected_gates.size() == 0) begin
                    $error("unexpected result %h", m_axis_tdata);
                    fail_count++;
                end else begin
                    g = expected_gates.pop_front();
                    if (got.en_u !== g.en_u) begin
                        $error("enable_u: expected %0d, got %0d", g.en_u, got.en_u);
                        fail_count++;
                    end
                    if (got.en_v !== g.en_v) begin
                        $error("enable_v: expected %0d, got %0d", g.en_v, got.en_v);
                        fail_count++;
                    end
                    if (got.en_w !== g.en_w) begin
                        $error("enable_w: expected %0d, got %0d", g.en_w, got.en_w);
                        fail_count++;
                    end
                    if (got.cmp_u !== g.cmp_u) begin
                        $error("compare_u: expected %0d, got %0d", g.cmp_u, got.cmp_u);
                        fail_count++;
                    end
                    if (got.cmp_v !== g.cmp_v) begin
                        $error("compare_v: expected %0d, got %0d", g.cmp_v, got.cmp_v);
                        fail_count++;
                    end
                    if (got.cmp_w !== g.cmp_w) begin
                        $error("compare_w: expected %0d, got %0d", g.cmp_w, got.cmp_w);
                        fail_count++;
                    end
                end
            end
        end
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout with %0d results outstanding", expected_gates.size());
            $display("bldc_six_step_commutator: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic push_request(input logic [1:0] cmd, input int angle, input int duty);
        t_req r;
        r.cmd   = cmd;
        r.angle = 16'(angle);
        r.duty  = 16'(duty);
        pending_requests.push_back(r);
    endtask

    task automatic settle();
        while (pending_requests.size() != 0 || s_axis_tvalid || expected_gates.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [15:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {16'($urandom), value};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        if (addr == ADDR_PERIOD) begin
            pwm_period_model = value;
        end
        n_periods++;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic random_requests(input int count);
        int          made;
        int          cmd_pick;
        int          angle;
        int          duty;
        logic [1:0]  cmd;
        int          edges[7];
        int          thresh[4];
        int          extremes[3];
        edges    = '{59, 60, 179, 180, 239, 240, 359};
        thresh   = '{29491, 29492, -29491, -29492};
        extremes = '{-32768, 32767, 0};
        made = 0;
        while (made < count) begin
            cmd_pick = $urandom_range(99);
            if (cmd_pick < 70 || cmd_pick >= 95) begin
                cmd = CMD_DRIVE;
            end else if (cmd_pick < 80) begin
                cmd = CMD_LOCK;
            end else if (cmd_pick < 90) begin
                cmd = CMD_FREE;
            end else begin
                cmd = CMD_UNUSED;
            end
            case ($urandom_range(9))
                0:             angle = -int'($urandom_range(1, 32768));
                1, 2, 3, 4, 5: angle = $urandom_range(0, 719);
                6, 7, 8:       angle = $urandom_range(0, 32767);
                default:       angle = FULL_TURN * $urandom_range(0, 90) + edges[$urandom_range(6)];
            endcase
            case ($urandom_range(9))
                0:       duty = extremes[$urandom_range(2)];
                1:       duty = thresh[$urandom_range(3)];
                default: duty = int'($signed(16'($urandom)));
            endcase
            push_request(cmd, angle, duty);
            if (cmd != CMD_UNUSED) begin
                made++;
            end
        end
    endtask

    initial begin : stimulus
        int i;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // sector edges, duty extremes and clamp thresholds at the reset period
        push_request(CMD_LOCK, -1, 12345);
        push_request(CMD_FREE, 32767, -32768);
        push_request(CMD_UNUSED, 90, 1000);
        push_request(CMD_DRIVE, 0, 0);
        push_request(CMD_DRIVE, 59, 32767);
        push_request(CMD_DRIVE, 60, -32768);
        push_request(CMD_DRIVE, 179, 32767);
        push_request(CMD_DRIVE, 180, -32768);
        push_request(CMD_DRIVE, 239, 16384);
        push_request(CMD_DRIVE, 240, -16384);
        push_request(CMD_DRIVE, 359, 100);
        push_request(CMD_DRIVE, 360, -100);
        push_request(CMD_DRIVE, 32767, 32767);
        push_request(CMD_DRIVE, -1, 0);
        push_request(CMD_DRIVE, -32768, 5);
        push_request(CMD_DRIVE, 90, -29492);
        push_request(CMD_DRIVE, 90, -29491);
        push_request(CMD_DRIVE, 90, 29491);
        push_request(CMD_DRIVE, 90, 29492);
        push_request(CMD_DRIVE, 300, 29492);
        push_request(CMD_DRIVE, 300, -29492);
        push_request(CMD_DRIVE, 300, -32768);
        random_requests(PHASE_ITEMS);
        settle();

        no_stall = 1'b1;
        write_reg(ADDR_PERIOD, 16'hFFFF);
        random_requests(PHASE_ITEMS);
        settle();
        no_stall = 1'b0;

        write_reg(ADDR_PERIOD, 16'd1);
        random_requests(PHASE_ITEMS);
        settle();

        // zero period, every compare comes out zero
        write_reg(ADDR_PERIOD, 16'd0);
        random_requests(PHASE_ITEMS);
        settle();

        for (i = 0; i < 3; i++) begin
            write_reg(ADDR_PERIOD, 16'($urandom_range(2, 65534)));
            random_requests(PHASE_ITEMS);
            settle();
        end

        // write outside the register map must leave the period alone
        write_reg(ADDR_UNMAPPED, 16'($urandom_range(1, 65535)));
        random_requests(PHASE_ITEMS);
        settle();

        $display("%0d requests (%0d drive, %0d lock, %0d free, %0d without result)",
                 n_requests, n_drive, n_lock, n_free, n_dropped);
        $display("%0d results checked over %0d register writes", n_results, n_periods - 1);
        if (fail_count == 0 && expected_gates.size() == 0) begin
            $display("bldc_six_step_commutator: match");
        end else begin
            $display("bldc_six_step_commutator: mismatch");
        end
        $finish;
    end

endmodule
